>>> design/nsrq_pkg.sv
// package for the noise-shaped 24-bit requantizer
// widths, limits, result type and the 40-bit saturation helper; no dependencies
package nsrq_pkg;

  localparam int FRACTION_BITS_DEF = 8;
  localparam int SAMPLE_W          = 32;
  localparam int QUANT_W           = 24;
  localparam int STATE_W           = 40;
  // working width with headroom for the sums before saturation
  localparam int CALC_W            = 44;
  localparam int CLIP_LIMIT        = 8388600;

  localparam logic signed [CALC_W-1:0] STATE_MAX =
    CALC_W'((64'sd1 <<< (STATE_W - 1)) - 64'sd1);
  localparam logic signed [CALC_W-1:0] STATE_MIN =
    CALC_W'(-(64'sd1 <<< (STATE_W - 1)));
  localparam logic signed [CALC_W-1:0] CLIP_POS = CALC_W'(CLIP_LIMIT);
  localparam logic signed [CALC_W-1:0] CLIP_NEG = CALC_W'(-CLIP_LIMIT);

  typedef struct packed {
    logic signed [QUANT_W-1:0] quantized;
    logic                      clipped;
  } nsrq_result_t;

  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [CALC_W-1:0] v
  );
    logic signed [CALC_W-1:0] r;
    if (v > STATE_MAX) begin
      r = STATE_MAX;
    end else if (v < STATE_MIN) begin
      r = STATE_MIN;
    end else begin
      r = v;
    end
    return r[STATE_W-1:0];
  endfunction

endpackage

>>> design/nsrq_datapath.sv
// noise-shaping state registers and the single-pass update of one item
// depends on nsrq_pkg
module nsrq_datapath import nsrq_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output nsrq_result_t               result_o
);

  localparam int SHL = (FRACTION_BITS >= 8) ? FRACTION_BITS - 8 : 0;
  localparam int SHR = (FRACTION_BITS < 8) ? 8 - FRACTION_BITS : 0;

  logic signed [STATE_W-1:0] prev_q, prev_d;
  logic signed [STATE_W-1:0] older_q, older_d;
  logic signed [STATE_W-1:0] acc_q, acc_d;

  logic signed [STATE_W-1:0] x;
  logic signed [CALC_W-1:0]  adj;
  logic signed [STATE_W-1:0] prev_sat;
  logic signed [CALC_W-1:0]  twice;
  logic signed [CALC_W-1:0]  rhs;
  logic                      round_up;
  logic signed [CALC_W-1:0]  floor_v;
  logic signed [CALC_W-1:0]  outv;
  logic signed [CALC_W-1:0]  acc_sum;
  logic signed [STATE_W-1:0] acc_sat;
  logic                      clip_hi, clip_lo;

  always_comb begin
    // input scaled to fixed point below the 24-bit lsb
    x        = (STATE_W'(sample_i) <<< SHL) >>> SHR;
    adj      = CALC_W'(prev_q) - CALC_W'(acc_q >>> 3);
    prev_sat = sat_state(adj);
    twice    = CALC_W'(prev_sat) + CALC_W'(prev_sat);
    rhs      = CALC_W'(x) + CALC_W'(older_q);
    round_up = twice < rhs;
    floor_v  = CALC_W'(prev_sat) >>> FRACTION_BITS;
    outv     = floor_v + {{(CALC_W-1){1'b0}}, round_up};
    acc_sum  = CALC_W'(acc_q) + (outv <<< FRACTION_BITS) - CALC_W'(x);
    acc_sat  = sat_state(acc_sum);
    clip_hi  = outv > CLIP_POS;
    clip_lo  = outv < CLIP_NEG;

    result_o.clipped = clip_hi | clip_lo;
    if (clip_hi) begin
      result_o.quantized = CLIP_POS[QUANT_W-1:0];
    end else if (clip_lo) begin
      result_o.quantized = CLIP_NEG[QUANT_W-1:0];
    end else begin
      result_o.quantized = outv[QUANT_W-1:0];
    end

    prev_d  = x;
    older_d = prev_sat;
    // halve the accumulator after saturation when the output clips
    acc_d   = (clip_hi | clip_lo) ? (acc_sat >>> 1) : acc_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      older_q <= '0;
      acc_q   <= '0;
    end else if (fire_i) begin
      prev_q  <= prev_d;
      older_q <= older_d;
      acc_q   <= acc_d;
    end
  end

endmodule

>>> design/noise_shaped_requantizer_24bit_core.sv
// top level of the noise-shaped 24-bit requantizer
// input register, datapath and result register; depends on nsrq_pkg, nsrq_datapath
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+------------------------
//   sample   | sample_valid_i / sample_ready_o | sample_i (32, signed)
//   result   | result_valid_o / result_ready_i | quantized_o (24, signed), clipped_o
//
// one item per clock sustained while results are taken; an item is accepted into the input
// register and is processed into the result register once that register is empty or
// being emptied, and its result is offered from there.
// the loop through the accumulator and older sample (subtract, saturate, compare,
// add, saturate) is the longest path.
// reset clears the state and the valid flags of the input and result registers.
// a stalled result holds; with the result stalled and the input register full the
// input ready drops, and the input register keeps accepting while the result
// register empties in the same cycle.
module noise_shaped_requantizer_24bit_core import nsrq_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       sample_valid_i,
  output logic                       sample_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       result_valid_o,
  input  logic                       result_ready_i,
  output logic signed [QUANT_W-1:0]  quantized_o,
  output logic                       clipped_o
);

  logic                       in_valid_q;
  logic signed [SAMPLE_W-1:0] in_sample_q;
  logic                       out_valid_q;
  nsrq_result_t               out_q;
  nsrq_result_t               result;
  logic                       fire;

  // item moves from the input register into the result register
  assign fire           = in_valid_q & (~out_valid_q | result_ready_i);
  assign sample_ready_o = ~in_valid_q | fire;

  nsrq_datapath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .sample_i(in_sample_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample_ready_o) begin
        in_valid_q <= sample_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_ready_o && sample_valid_i) begin
      in_sample_q <= sample_i;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  assign result_valid_o = out_valid_q;
  assign quantized_o    = out_q.quantized;
  assign clipped_o      = out_q.clipped;

endmodule
